// ===== rtl/sorted_list_engine_core_defines.svh =====
// Assertion macros shared by the sorted list engine RTL
`ifndef SORTED_LIST_ENGINE_CORE_DEFINES_SVH
`define SORTED_LIST_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SLE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted list engine: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define SLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted list engine: next-cycle check failed");

`endif

// ===== rtl/sle_pkg.sv =====
// Shared types and codes of the sorted list engine
`default_nettype none

package sle_pkg;

  localparam int OP_W  = 3;
  localparam int CNT_W = 5;

  localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
  localparam logic [OP_W-1:0] OP_DEL_VALUE = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH    = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DELV,
    S_SRCH
  } state_t;

  // What every cell does with its entry this cycle
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_SHIFT_GE,
    CM_SHIFT_FROM
  } cell_mode_t;

  typedef struct packed {
    logic lt;        // entry valid and below the key
    logic eq;        // entry valid and equal to the key
    logic sel_eq;    // cursor cell matches
    logic sel_lt;    // cursor cell below the key
    logic sel_last;  // cursor cell matches and right neighbor does not
  } cell_flags_t;

endpackage

`default_nettype wire

// ===== rtl/sle_cell.sv =====
// One list cell: holds one entry, compares it to the key, shifts with its neighbors
`default_nettype none

module sle_cell #(
  parameter int VALUE_BITS = 32,
  parameter int DEPTH      = 16,
  parameter int INDEX      = 0
) (
  input  wire                                clk,
  input  var sle_pkg::cell_mode_t            mode,
  input  wire signed [VALUE_BITS-1:0]        key,
  input  wire [$clog2(DEPTH+1)-1:0]          occ,
  input  wire [$clog2(DEPTH)-1:0]            from_idx,
  input  wire [$clog2(DEPTH)-1:0]            cur_idx,
  input  wire signed [VALUE_BITS-1:0]        left_val,
  input  wire                                left_lt,
  input  wire signed [VALUE_BITS-1:0]        right_val,
  input  wire                                right_eq,
  output logic signed [VALUE_BITS-1:0]       val,
  output sle_pkg::cell_flags_t               flags
);
  import sle_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic signed [VALUE_BITS-1:0] val_next;
  logic valid;
  logic lt;
  logic eq;
  logic sel;
  logic ge;
  logic at_from;

  assign valid   = CW'(INDEX) < occ;
  assign lt      = valid && (val < key);
  assign eq      = valid && (val == key);
  assign ge      = valid && !lt;
  assign sel     = cur_idx == IW'(INDEX);
  assign at_from = IW'(INDEX) >= from_idx;

  assign flags.lt       = lt;
  assign flags.eq       = eq;
  assign flags.sel_eq   = sel && eq;
  assign flags.sel_lt   = sel && lt;
  assign flags.sel_last = sel && eq && !right_eq;

  always_comb begin
    val_next = val;
    case (mode)
      CM_INSERT: begin
        // smaller entries stay; the first cell not below the key takes it
        if (!lt) begin
          val_next = left_lt ? key : left_val;
        end
      end
      CM_SHIFT_GE: begin
        if (ge) begin
          val_next = right_val;
        end
      end
      CM_SHIFT_FROM: begin
        if (at_from) begin
          val_next = right_val;
        end
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_list_engine_core.sv =====
// Sorted list engine top level: control sequencer, cell chain and result register
//
// Keeps up to DEPTH signed values in ascending order in a chain of cells.
// Input channel (in_valid / in_stall): operation, value, position. An item is
// taken at a clock edge with in_valid high and in_stall low; in_stall is high
// from the edge after acceptance until the item's last result is loaded.
// Output channel (out_valid / out_stall): status, found_position,
// removed_count, occupancy_after, last. A result is held in the output
// register until taken; last marks the final result of an item.
// Insert, delete position, clear and unused codes are done in the execute state.
// Delete value removes matching entries with one cell-chain shift per removal. Search
// walks a cursor one cell per cycle from the first cell, holding at a match while the
// output register is stalled, and gives a result for each match, or one result when
// the scan stops without a hit. An item is finished before the next one is taken.
// A stalled output register holds the sequencer at its next result. Insert,
// delete position and clear change the list only in the cycle their result is
// loaded; delete value keeps removing matches and search keeps scanning up to
// that result.
// Reset (rst, synchronous) empties the list and drops any pending result;
// no clearing pass is needed.
`default_nettype none

`include "sorted_list_engine_core_defines.svh"

module sorted_list_engine_core #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire [sle_pkg::OP_W-1:0]              operation,
  input  wire signed [VALUE_BITS-1:0]          value,
  input  wire [sle_pkg::CNT_W-1:0]             position,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [1:0]                           status,
  output logic [sle_pkg::CNT_W-1:0]            found_position,
  output logic [sle_pkg::CNT_W-1:0]            removed_count,
  output logic [sle_pkg::CNT_W-1:0]            occupancy_after,
  output logic                                 last
);
  import sle_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int PW = (CW > CNT_W) ? CW : CNT_W;

  state_t state;
  state_t state_next;

  logic [OP_W-1:0]              op_r;
  logic signed [VALUE_BITS-1:0] key_r;
  logic [CNT_W-1:0]             pos_r;
  logic [CW-1:0]                occ;
  logic [CW-1:0]                occ_next;
  logic [CW-1:0]                cnt;
  logic [CW-1:0]                cnt_next;
  logic [IW-1:0]                cur_idx;
  logic [IW-1:0]                cur_next;

  cell_mode_t  cell_mode;
  logic        emit;
  status_t     e_status;
  logic [PW-1:0] e_pos;
  logic [PW-1:0] e_removed;
  logic        e_last;

  logic in_accept;
  logic out_free;
  logic full;
  logic range_ok;
  logic any_eq;
  logic c_valid;
  logic c_end;
  logic c_eq;
  logic c_lt;
  logic c_last;
  logic srch_hit;
  logic srch_miss;

  logic [PW-1:0] pos_w;
  logic [PW-1:0] occ_w;
  logic [PW-1:0] from_w;
  logic [PW-1:0] occ_out_w;
  logic [IW-1:0] from_idx;

  logic signed [VALUE_BITS-1:0] vals [DEPTH];
  cell_flags_t                  flags [DEPTH];
  logic [DEPTH-1:0] eq_v;
  logic [DEPTH-1:0] sel_eq_v;
  logic [DEPTH-1:0] sel_lt_v;
  logic [DEPTH-1:0] sel_last_v;

  // ---------------------------------------------------------------- cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_BITS-1:0] lv;
    logic signed [VALUE_BITS-1:0] rv;
    logic                         llt;
    logic                         req;

    if (i == 0) begin : g_first
      assign lv  = key_r;
      assign llt = 1'b1;
    end else begin : g_mid
      assign lv  = vals[i-1];
      assign llt = flags[i-1].lt;
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rv  = key_r;
      assign req = 1'b0;
    end else begin : g_body
      assign rv  = vals[i+1];
      assign req = flags[i+1].eq;
    end

    sle_cell #(
      .VALUE_BITS (VALUE_BITS),
      .DEPTH      (DEPTH),
      .INDEX      (i)
    ) u_cell (
      .clk       (clk),
      .mode      (cell_mode),
      .key       (key_r),
      .occ       (occ),
      .from_idx  (from_idx),
      .cur_idx   (cur_idx),
      .left_val  (lv),
      .left_lt   (llt),
      .right_val (rv),
      .right_eq  (req),
      .val       (vals[i]),
      .flags     (flags[i])
    );

    assign eq_v[i]       = flags[i].eq;
    assign sel_eq_v[i]   = flags[i].sel_eq;
    assign sel_lt_v[i]   = flags[i].sel_lt;
    assign sel_last_v[i] = flags[i].sel_last;
  end

  // ------------------------------------------------------------ shared decode
  assign in_stall  = state != S_IDLE;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign full     = occ == CW'(DEPTH);
  assign pos_w    = PW'(pos_r);
  assign occ_w    = PW'(occ);
  assign range_ok = (pos_w != '0) && (pos_w <= occ_w);
  assign from_w   = pos_w - PW'(1);
  assign from_idx = from_w[IW-1:0];
  assign any_eq   = |eq_v;

  assign c_valid  = CW'(cur_idx) < occ;
  assign c_end    = cur_idx == IW'(DEPTH - 1);
  assign c_eq     = |sel_eq_v;
  assign c_lt     = |sel_lt_v;
  assign c_last   = |sel_last_v;
  // matches are contiguous: a non-match past the run, a larger entry or the
  // end of the list closes the search without a hit
  assign srch_hit  = c_eq;
  assign srch_miss = !c_eq && (!c_valid || !c_lt || c_end);

  assign occ_out_w = PW'(occ_next);

  // --------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (operation == OP_DEL_VALUE) begin
            state_next = S_DELV;
          end else if (operation == OP_SEARCH) begin
            state_next = S_SRCH;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_DELV: begin
        if (!any_eq && out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SRCH: begin
        if (out_free && ((srch_hit && c_last) || srch_miss)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ------------------------------------------------------------------ outputs
  always_comb begin
    cell_mode = CM_HOLD;
    emit      = 1'b0;
    e_status  = ST_OK;
    e_pos     = '0;
    e_removed = '0;
    e_last    = 1'b1;
    occ_next  = occ;
    cnt_next  = cnt;
    cur_next  = cur_idx;
    case (state)
      S_EXEC: begin
        if (out_free) begin
          emit = 1'b1;
          case (op_r)
            OP_INSERT: begin
              if (full) begin
                e_status = ST_FULL;
              end else begin
                cell_mode = CM_INSERT;
                occ_next  = occ + CW'(1);
              end
            end
            OP_DEL_POS: begin
              if (range_ok) begin
                cell_mode = CM_SHIFT_FROM;
                occ_next  = occ - CW'(1);
                e_removed = PW'(1);
              end else begin
                e_status = ST_RANGE;
              end
            end
            OP_CLEAR: begin
              occ_next  = '0;
              e_removed = occ_w;
            end
            default: e_status = ST_OK;
          endcase
        end
      end
      S_DELV: begin
        if (any_eq) begin
          // drop the first equal entry; all entries from it on move left
          cell_mode = CM_SHIFT_GE;
          occ_next  = occ - CW'(1);
          cnt_next  = cnt + CW'(1);
        end else if (out_free) begin
          emit      = 1'b1;
          e_status  = (cnt != '0) ? ST_OK : ST_NOT_FOUND;
          e_removed = PW'(cnt);
        end
      end
      S_SRCH: begin
        if (srch_hit) begin
          if (out_free) begin
            emit   = 1'b1;
            e_pos  = PW'(cur_idx) + PW'(1);
            e_last = c_last;
            if (!c_last) begin
              cur_next = cur_idx + IW'(1);
            end
          end
        end else if (srch_miss) begin
          if (out_free) begin
            emit     = 1'b1;
            e_status = ST_NOT_FOUND;
          end
        end else begin
          cur_next = cur_idx + IW'(1);
        end
      end
      default: cell_mode = CM_HOLD;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      cnt       <= '0;
      cur_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      if (in_accept) begin
        cnt     <= '0;
        cur_idx <= '0;
      end else begin
        cnt     <= cnt_next;
        cur_idx <= cur_next;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r  <= operation;
      key_r <= value;
      pos_r <= position;
    end
    if (emit) begin
      status          <= e_status;
      found_position  <= e_pos[CNT_W-1:0];
      removed_count   <= e_removed[CNT_W-1:0];
      occupancy_after <= occ_out_w[CNT_W-1:0];
      last            <= e_last;
    end
  end

  // --------------------------------------------------------------- assertions
  `SLE_ASSERT_IMPL(a_occ_bound, 1'b1, occ <= CW'(DEPTH))
  `SLE_ASSERT_IMPL(a_partial_only_search, out_valid && !last, op_r == OP_SEARCH)
  `SLE_ASSERT_NEXT(a_insert_grows, state == S_EXEC && out_free && op_r == OP_INSERT && !full,
                   occ == $past(occ) + CW'(1))
  `SLE_ASSERT_NEXT(a_delv_no_growth, state == S_DELV, occ <= $past(occ))

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the sorted list engine: directed table, random items, result checks
module testbench;
  import sle_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 3'd7;
  localparam int RANDOM_ITEMS   = 250;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int DIRECTED_ROWS  = 15;

  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] found_position;
    logic [CNT_W-1:0] removed_count;
    logic [CNT_W-1:0] occupancy_after;
    logic             last;
  } list_result_t;

  // copies > 1 repeats the row; typed rows carry their own single expected result
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [31:0]      val;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] copies;
    logic             typed;
    status_t          st;
    logic [CNT_W-1:0] removed;
    logic [CNT_W-1:0] occ;
  } stim_row_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          operation = '0;
  logic signed [31:0]       value = '0;
  logic [CNT_W-1:0]         position = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               status;
  logic [CNT_W-1:0]         found_position;
  logic [CNT_W-1:0]         removed_count;
  logic [CNT_W-1:0]         occupancy_after;
  logic                     last;

  logic signed [31:0] list_vals [LIST_DEPTH];
  int unsigned        list_count = 0;
  list_result_t       expected_results [$];
  int                 fail_count = 0;
  bit                 no_idle = 1'b0;
  bit                 rx_no_idle = 1'b0;
  int                 stall_left = 0;
  int                 results_taken = 0;
  logic               long_hold = 1'b0;
  logic               random_phase = 1'b0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_SEARCH,       32'h0,        5'd0,  5'd1,  1'b1, ST_NOT_FOUND, 5'd0, 5'd0},
    '{OP_DEL_VALUE,    32'h0,        5'd0,  5'd1,  1'b1, ST_NOT_FOUND, 5'd0, 5'd0},
    '{OP_DEL_POS,      32'h0,        5'd1,  5'd1,  1'b1, ST_RANGE,     5'd0, 5'd0},
    '{OP_INSERT,       32'h7fffffff, 5'd0,  5'd1,  1'b1, ST_OK,        5'd0, 5'd1},
    '{OP_INSERT,       32'h80000000, 5'd31, 5'd1,  1'b1, ST_OK,        5'd0, 5'd2},
    '{OP_INSERT,       32'h0,        5'd0,  5'd14, 1'b0, ST_OK,        5'd0, 5'd0},
    '{OP_INSERT,       32'hffffffff, 5'd0,  5'd1,  1'b1, ST_FULL,      5'd0, 5'd16},
    '{OP_SEARCH,       32'h0,        5'd0,  5'd1,  1'b0, ST_OK,        5'd0, 5'd0},
    '{OP_DEL_POS,      32'h0,        5'd0,  5'd1,  1'b1, ST_RANGE,     5'd0, 5'd16},
    '{OP_DEL_POS,      32'h0,        5'd31, 5'd1,  1'b1, ST_RANGE,     5'd0, 5'd16},
    '{OP_DEL_POS,      32'h0,        5'd16, 5'd1,  1'b1, ST_OK,        5'd1, 5'd15},
    '{OP_SEARCH,       32'h7fffffff, 5'd0,  5'd1,  1'b1, ST_NOT_FOUND, 5'd0, 5'd15},
    '{OP_DEL_VALUE,    32'h0,        5'd0,  5'd1,  1'b0, ST_OK,        5'd0, 5'd0},
    '{OP_LAST_UNUSED,  32'hffffffff, 5'd31, 5'd1,  1'b1, ST_OK,        5'd0, 5'd1},
    '{OP_CLEAR,        32'h0,        5'd0,  5'd1,  1'b1, ST_OK,        5'd1, 5'd0}
  };

  sorted_list_engine_core dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .value           (value),
    .position        (position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .found_position  (found_position),
    .removed_count   (removed_count),
    .occupancy_after (occupancy_after),
    .last            (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic list_result_t make_result(status_t st, int fpos, int removed, int occ,
                                               bit fin);
    list_result_t res;
    res.status          = st;
    res.found_position  = fpos[CNT_W-1:0];
    res.removed_count   = removed[CNT_W-1:0];
    res.occupancy_after = occ[CNT_W-1:0];
    res.last            = fin;
    return res;
  endfunction

  // Applies one operation to the list copy and queues the results it should produce
  function automatic void predict_list_op(logic [OP_W-1:0] op, logic signed [31:0] val,
                                          logic [CNT_W-1:0] pos);
    int idx;
    int keep;
    int hits;
    int seen;
    case (op)
      OP_INSERT: begin
        if (list_count >= LIST_DEPTH) begin
          expected_results.push_back(make_result(ST_FULL, 0, 0, list_count, 1'b1));
        end else begin
          idx = 0;
          while (idx < list_count && list_vals[idx] < val) idx++;
          for (int j = list_count; j > idx; j--) list_vals[j] = list_vals[j-1];
          list_vals[idx] = val;
          list_count++;
          expected_results.push_back(make_result(ST_OK, 0, 0, list_count, 1'b1));
        end
      end
      OP_DEL_VALUE: begin
        keep = 0;
        hits = 0;
        for (int i = 0; i < list_count; i++) begin
          if (list_vals[i] == val) hits++;
          else begin
            list_vals[keep] = list_vals[i];
            keep++;
          end
        end
        list_count = keep;
        expected_results.push_back(make_result(hits != 0 ? ST_OK : ST_NOT_FOUND, 0, hits,
                                               list_count, 1'b1));
      end
      OP_DEL_POS: begin
        if (pos < 1 || pos > list_count) begin
          expected_results.push_back(make_result(ST_RANGE, 0, 0, list_count, 1'b1));
        end else begin
          for (int i = pos - 1; i + 1 < list_count; i++) list_vals[i] = list_vals[i+1];
          list_count--;
          expected_results.push_back(make_result(ST_OK, 0, 1, list_count, 1'b1));
        end
      end
      OP_SEARCH: begin
        hits = 0;
        for (int i = 0; i < list_count; i++) if (list_vals[i] == val) hits++;
        if (hits == 0) begin
          expected_results.push_back(make_result(ST_NOT_FOUND, 0, 0, list_count, 1'b1));
        end else begin
          seen = 0;
          for (int i = 0; i < list_count; i++) begin
            if (list_vals[i] == val) begin
              seen++;
              expected_results.push_back(make_result(ST_OK, i + 1, 0, list_count,
                                                     seen == hits));
            end
          end
        end
      end
      OP_CLEAR: begin
        hits = list_count;
        list_count = 0;
        expected_results.push_back(make_result(ST_OK, 0, hits, 0, 1'b1));
      end
      default: expected_results.push_back(make_result(ST_OK, 0, 0, list_count, 1'b1));
    endcase
  endfunction

  task automatic send_list_item(input logic [OP_W-1:0] op, input logic signed [31:0] val,
                                input logic [CNT_W-1:0] pos, input logic typed,
                                input status_t st, input logic [CNT_W-1:0] removed,
                                input logic [CNT_W-1:0] occ);
    int gap;
    int queued;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    value     <= val;
    position  <= pos;
    do @(posedge clk); while (in_stall);
    queued = expected_results.size();
    predict_list_op(op, val, pos);
    // hand-written expectation replaces the computed one
    if (typed) begin
      while (expected_results.size() > queued) void'(expected_results.pop_back());
      expected_results.push_back(make_result(st, 0, removed, occ, 1'b1));
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d pos %0d removed %0d occ %0d last %0d",
                 $time, status, found_position, removed_count, occupancy_after, last);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", want.status, status);
        check_field("found_position", want.found_position, found_position);
        check_field("removed_count", want.removed_count, removed_count);
        check_field("occupancy_after", want.occupancy_after, occupancy_after);
        check_field("last", want.last, last);
      end
    end
  end

  always @(posedge clk) begin : result_sink
    if (out_valid && !out_stall) begin
      results_taken++;
      if (results_taken % 40 == 0) rx_no_idle = ($urandom_range(0, 3) == 0);
      stall_left = rx_no_idle ? 0 : $urandom_range(0, 5);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= long_hold || (stall_left > 0);
  end

  // Long output stall in the random phase so the engine backs up into its input
  initial begin : output_backpressure
    wait (random_phase);
    repeat (40) @(posedge clk);
    long_hold <= 1'b1;
    repeat (150) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("sorted_list_engine_core verification failed");
    $finish;
  end

  initial begin : stimulus
    int pick;
    logic [OP_W-1:0]    op;
    logic signed [31:0] val;
    logic [CNT_W-1:0]   pos;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      repeat (directed_rows[r].copies)
        send_list_item(directed_rows[r].op, directed_rows[r].val, directed_rows[r].pos,
                       directed_rows[r].typed, directed_rows[r].st,
                       directed_rows[r].removed, directed_rows[r].occ);
    end

    random_phase <= 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40)      op = OP_INSERT;
      else if (pick < 58) op = OP_SEARCH;
      else if (pick < 73) op = OP_DEL_VALUE;
      else if (pick < 93) op = OP_DEL_POS;
      else if (pick < 97) op = OP_CLEAR;
      else                op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
      // mostly values already held or from a small pool, so matches and duplicates are common
      pick = $urandom_range(0, 9);
      if (list_count > 0 && pick < 5) val = list_vals[$urandom_range(0, list_count - 1)];
      else if (pick < 8)              val = $signed($urandom_range(0, 7)) - 4;
      else if (pick == 8)             val = $urandom;
      else                            val = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      if ($urandom_range(0, 3) == 0) pos = CNT_W'($urandom_range(0, 31));
      else                           pos = CNT_W'($urandom_range(1, list_count + 1));
      send_list_item(op, val, pos, 1'b0, ST_OK, '0, '0);
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("sorted_list_engine_core verification clean");
    end else begin
      $display("sorted_list_engine_core verification failed");
    end
    $finish;
  end

endmodule
